// ----- design/bmp_stream_decoder_assert.svh -----
// Assertion macros shared by the bmp stream decoder modules.
// No dependencies; assertions compile away when SYNTHESIS is defined.
`ifndef BMP_STREAM_DECODER_ASSERT_SVH
`define BMP_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
// condition holds at every edge out of reset
`define BMP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);
`else
`define BMP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define BMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define BMP_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- design/bmp_dec_pkg.sv -----
// Types, codes and constants of the bmp stream decoder.
// No dependencies; used by the core, the output buffer and the top level.
package bmp_dec_pkg;

	// largest accepted width and absolute height
	localparam int unsigned MAX_DIM = 4096;

	// header layout
	localparam logic [31:0] HDR_LEN   = 32'd54;
	localparam logic [31:0] HDR_LAST  = 32'd53;
	localparam logic [15:0] BMP_MAGIC = 16'h4D42;
	localparam logic [15:0] DEPTH_24  = 16'd24;
	localparam logic [15:0] DEPTH_32  = 16'd32;
	localparam logic [5:0]  POS_SIG   = 6'd0;
	localparam logic [5:0]  POS_OFS   = 6'd10;
	localparam logic [5:0]  POS_WID   = 6'd18;
	localparam logic [5:0]  POS_HGT   = 6'd22;
	localparam logic [5:0]  POS_DEP   = 6'd28;
	localparam logic [5:0]  POS_CMP   = 6'd30;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD,
		PH_DRAIN
	} bmp_phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_ERROR  = 2'd2
	} bmp_kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SIG    = 3'd1,
		ST_COMP   = 3'd2,
		ST_DEPTH  = 3'd3,
		ST_DIM    = 3'd4,
		ST_OFFSET = 3'd5,
		ST_TRUNC  = 3'd6
	} bmp_status_t;

	// one result word
	typedef struct packed {
		bmp_kind_t   kind;
		bmp_status_t status;
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        final_pixel;
	} bmp_result_t;

	// result word handed from the core to the output buffer
	typedef struct packed {
		logic        push;
		bmp_result_t data;
	} bmp_push_t;

endpackage

// ----- design/bmp_dec_if.sv -----
// Stream interfaces of the bmp stream decoder: file bytes in, result words out.
// No dependencies.
interface bmp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, in_byte, last_byte, input ready);
	modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface bmp_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [2:0]  status;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic        final_pixel;

	modport source (output valid, result_kind, status, pixel_x, pixel_y, red, green, blue,
		alpha, image_width, image_height, final_pixel, input ready);
	modport sink (input valid, result_kind, status, pixel_x, pixel_y, red, green, blue,
		alpha, image_width, image_height, final_pixel, output ready);
endinterface

// ----- design/bmp_stream_decoder.sv -----
// Streaming decoder for uncompressed 24- and 32-bit BMP files: takes one file
// byte per clock and gives header, pixel and error words. It takes one byte in
// every cycle that the two-word output buffer is not full, so with the result
// side always ready the rate is one byte per cycle; each result word passes
// through the output buffer registers. A pixel word follows the last channel
// byte of the pixel, the header word follows header byte 53, and any byte
// marked last_byte returns the decoder to its start state for the next file.
// There is no clearing pass after reset. Depends on bmp_dec_pkg and bmp_dec_if.
module bmp_stream_decoder #(
	parameter int unsigned MAX_DIM = bmp_dec_pkg::MAX_DIM
) (
	input  logic         clk,
	input  logic         arst_n,
	bmp_byte_if.sink     bytes,
	bmp_result_if.source results
);
	import bmp_dec_pkg::*;

	bmp_push_t   core_push;
	bmp_result_t buf_data;
	logic        buf_full;
	logic        accept;

	// a byte is taken whenever the output buffer has room
	assign bytes.ready = !buf_full;
	assign accept      = bytes.valid && !buf_full;

	bmp_dec_core #(
		.MAX_DIM (MAX_DIM)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (bytes.in_byte),
		.last_byte (bytes.last_byte),
		.result    (core_push)
	);

	bmp_dec_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_in   (core_push),
		.full      (buf_full),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_data  (buf_data)
	);

	// result word onto the interface fields
	assign results.result_kind  = buf_data.kind;
	assign results.status       = buf_data.status;
	assign results.pixel_x      = buf_data.pixel_x;
	assign results.pixel_y      = buf_data.pixel_y;
	assign results.red          = buf_data.red;
	assign results.green        = buf_data.green;
	assign results.blue         = buf_data.blue;
	assign results.alpha        = buf_data.alpha;
	assign results.image_width  = buf_data.image_width;
	assign results.image_height = buf_data.image_height;
	assign results.final_pixel  = buf_data.final_pixel;

endmodule

// ----- design/bmp_dec_core.sv -----
// Byte-level parser of the bmp stream decoder: header capture and checks, skip,
// pixel assembly, row padding and coordinates. Depends on bmp_dec_pkg.
`include "bmp_stream_decoder_assert.svh"

module bmp_dec_core #(
	parameter int unsigned MAX_DIM = bmp_dec_pkg::MAX_DIM
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            in_byte,
	input  logic                  last_byte,
	output bmp_dec_pkg::bmp_push_t result
);
	import bmp_dec_pkg::*;

	bmp_phase_t  phase_q, phase_d;
	logic [31:0] pos_q;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [1:0]  bip_q;
	logic [1:0]  pad_q;

	// header fields, all written before they are checked
	logic [15:0] sig_q;
	logic [31:0] offset_q;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [15:0] depth_q;
	logic        comp_nz_q;

	// image state latched when the header is accepted
	logic        top_down_q;
	logic        is32_q;
	logic [12:0] img_w_q;
	logic [12:0] img_h_q;
	logic [31:0] skip_last_q;
	logic [23:0] held_q;

	logic [5:0]  pos6;
	logic [31:0] abs_h;
	bmp_status_t hdr_status;
	logic        hdr_end;
	logic        hdr_ok;
	logic [1:0]  last_idx;
	logic        pix_done;
	logic        row_end;
	logic        final_pix;
	logic [11:0] pix_y;
	logic [12:0] col_inc;
	logic [12:0] row_inc;
	logic        cmp_nz_byte;

	assign pos6 = pos_q[5:0];
	assign cmp_nz_byte = (in_byte != 8'd0);

	// header check on the registered fields
	assign abs_h = height_q[31] ? (~height_q + 32'd1) : height_q;

	always_comb begin
		priority if (sig_q != BMP_MAGIC) begin
			hdr_status = ST_SIG;
		end else if (comp_nz_q) begin
			hdr_status = ST_COMP;
		end else if (depth_q != DEPTH_24 && depth_q != DEPTH_32) begin
			hdr_status = ST_DEPTH;
		end else if (width_q[31] || width_q == 32'd0 || width_q > 32'(MAX_DIM)) begin
			hdr_status = ST_DIM;
		end else if (abs_h == 32'd0 || abs_h > 32'(MAX_DIM)) begin
			hdr_status = ST_DIM;
		end else if (offset_q < HDR_LEN) begin
			hdr_status = ST_OFFSET;
		end else begin
			hdr_status = ST_OK;
		end
	end

	assign hdr_end = (phase_q == PH_HEADER) && (pos_q == HDR_LAST);
	assign hdr_ok  = (hdr_status == ST_OK);

	// pixel position bookkeeping
	assign last_idx  = is32_q ? 2'd3 : 2'd2;
	assign pix_done  = (bip_q == last_idx);
	assign col_inc   = {1'b0, col_q} + 13'd1;
	assign row_inc   = {1'b0, row_q} + 13'd1;
	assign row_end   = (col_inc >= img_w_q);
	assign final_pix = row_end && (row_inc >= img_h_q);
	assign pix_y     = top_down_q ? row_q : 12'(img_h_q - 13'd1 - {1'b0, row_q});

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (last_byte) begin
				phase_d = PH_HEADER;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (hdr_end) begin
							if (!hdr_ok) begin
								phase_d = PH_DRAIN;
							end else if (offset_q == HDR_LEN) begin
								phase_d = PH_PIXEL;
							end else begin
								phase_d = PH_SKIP;
							end
						end
					end
					PH_SKIP: begin
						if (pos_q == skip_last_q) begin
							phase_d = PH_PIXEL;
						end
					end
					PH_PIXEL: begin
						if (pix_done) begin
							if (final_pix) begin
								phase_d = PH_DRAIN;
							end else if (row_end && !is32_q && img_w_q[1:0] != 2'd0) begin
								phase_d = PH_PAD;
							end
						end
					end
					PH_PAD: begin
						if (pad_q == 2'd1) begin
							phase_d = PH_PIXEL;
						end
					end
					PH_DRAIN: begin
						phase_d = PH_DRAIN;
					end
					default: begin
						phase_d = PH_HEADER;
					end
				endcase
			end
		end
	end

	// result word for the accepted byte
	always_comb begin
		result = '0;
		if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_end && !hdr_ok) begin
						result.push        = 1'b1;
						result.data.kind   = KIND_ERROR;
						result.data.status = hdr_status;
					end else if (last_byte) begin
						result.push        = 1'b1;
						result.data.kind   = KIND_ERROR;
						result.data.status = ST_TRUNC;
					end else if (hdr_end) begin
						result.push              = 1'b1;
						result.data.kind         = KIND_HEADER;
						result.data.status       = ST_OK;
						result.data.image_width  = width_q[12:0];
						result.data.image_height = abs_h[12:0];
					end
				end
				PH_SKIP, PH_PAD: begin
					if (last_byte) begin
						result.push        = 1'b1;
						result.data.kind   = KIND_ERROR;
						result.data.status = ST_TRUNC;
					end
				end
				PH_PIXEL: begin
					if (last_byte && !(pix_done && final_pix)) begin
						result.push        = 1'b1;
						result.data.kind   = KIND_ERROR;
						result.data.status = ST_TRUNC;
					end else if (pix_done) begin
						result.push              = 1'b1;
						result.data.kind         = KIND_PIXEL;
						result.data.status       = ST_OK;
						result.data.pixel_x      = col_q;
						result.data.pixel_y      = pix_y;
						result.data.red          = is32_q ? held_q[23:16] : in_byte;
						result.data.green        = held_q[15:8];
						result.data.blue         = held_q[7:0];
						result.data.alpha        = is32_q ? in_byte : ALPHA_OPAQUE;
						result.data.image_width  = img_w_q;
						result.data.image_height = img_h_q;
						result.data.final_pixel  = final_pix;
					end
				end
				PH_DRAIN: begin
					result.push = 1'b0;
				end
				default: begin
					result.push = 1'b0;
				end
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			bip_q   <= '0;
			pad_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept) begin
				if (last_byte) begin
					pos_q <= '0;
					col_q <= '0;
					row_q <= '0;
					bip_q <= '0;
					pad_q <= '0;
				end else begin
					unique case (phase_q)
						PH_HEADER, PH_SKIP: begin
							pos_q <= pos_q + 32'd1;
						end
						PH_PIXEL: begin
							if (!pix_done) begin
								bip_q <= bip_q + 2'd1;
							end else begin
								bip_q <= '0;
								if (!final_pix) begin
									if (row_end) begin
										col_q <= '0;
										row_q <= row_q + 12'd1;
										pad_q <= is32_q ? 2'd0 : img_w_q[1:0];
									end else begin
										col_q <= col_q + 12'd1;
									end
								end
							end
						end
						PH_PAD: begin
							pad_q <= pad_q - 2'd1;
						end
						PH_DRAIN: begin
							pad_q <= pad_q;
						end
						default: begin
							pad_q <= pad_q;
						end
					endcase
				end
			end
		end
	end

	// header capture, little-endian
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_HEADER) begin
			if (pos6 < POS_SIG + 6'd2) begin
				sig_q[{pos6[0], 3'b000} +: 8] <= in_byte;
			end else if (pos6 >= POS_OFS && pos6 < POS_OFS + 6'd4) begin
				offset_q[{2'(pos6 - POS_OFS), 3'b000} +: 8] <= in_byte;
			end else if (pos6 >= POS_WID && pos6 < POS_WID + 6'd4) begin
				width_q[{2'(pos6 - POS_WID), 3'b000} +: 8] <= in_byte;
			end else if (pos6 >= POS_HGT && pos6 < POS_HGT + 6'd4) begin
				height_q[{2'(pos6 - POS_HGT), 3'b000} +: 8] <= in_byte;
			end else if (pos6 >= POS_DEP && pos6 < POS_DEP + 6'd2) begin
				depth_q[{1'(pos6 - POS_DEP), 3'b000} +: 8] <= in_byte;
			end else if (pos6 == POS_CMP) begin
				comp_nz_q <= cmp_nz_byte;
			end else if (pos6 > POS_CMP && pos6 < POS_CMP + 6'd4) begin
				comp_nz_q <= comp_nz_q | cmp_nz_byte;
			end
		end
	end

	// image state latched on an accepted header
	always_ff @(posedge clk) begin
		if (accept && hdr_end && hdr_ok && !last_byte) begin
			top_down_q  <= height_q[31];
			is32_q      <= (depth_q == DEPTH_32);
			img_w_q     <= width_q[12:0];
			img_h_q     <= abs_h[12:0];
			skip_last_q <= offset_q - 32'd1;
		end
	end

	// channel bytes of the pixel being assembled
	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_PIXEL && !pix_done) begin
			unique case (bip_q)
				2'd0: held_q[7:0]   <= in_byte;
				2'd1: held_q[15:8]  <= in_byte;
				2'd2: held_q[23:16] <= in_byte;
				default: held_q <= held_q;
			endcase
		end
	end

	`BMP_ASSERT_NEXT(a_last_restarts, clk, arst_n, accept && last_byte, phase_q == PH_HEADER && pos_q == 32'd0 && bip_q == 2'd0, "last byte did not restart the parser")
	`BMP_ASSERT_IMPLY(a_push_needs_accept, clk, arst_n, result.push, accept, "result word without an accepted byte")
	`BMP_ASSERT_IMPLY(a_drain_silent, clk, arst_n, phase_q == PH_DRAIN, !result.push, "result word while draining")
	`BMP_ASSERT_IMPLY(a_pixel_bounds, clk, arst_n, phase_q == PH_PIXEL, 13'(col_q) < img_w_q && 13'(row_q) < img_h_q, "pixel counters outside the image")

endmodule

// ----- design/bmp_dec_outbuf.sv -----
// Two-word output buffer of the bmp stream decoder; lets the core take a byte
// while a result word waits. Depends on bmp_dec_pkg.
`include "bmp_stream_decoder_assert.svh"

module bmp_dec_outbuf (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bmp_dec_pkg::bmp_push_t  push_in,
	output logic                    full,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bmp_dec_pkg::bmp_result_t out_data
);
	import bmp_dec_pkg::*;

	bmp_result_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign full      = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push_in.push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push_in.push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push_in.push && pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// word storage
	always_ff @(posedge clk) begin
		if (push_in.push) begin
			mem_q[wr_ptr_q] <= push_in.data;
		end
	end

	`BMP_ASSERT_IMPLY(a_no_push_when_full, clk, arst_n, push_in.push, !full, "word pushed into a full buffer")
	`BMP_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q != 2'd3, "buffer count out of range")
	`BMP_ASSERT_NEXT(a_count_grows, clk, arst_n, push_in.push && !pop, count_q == $past(count_q) + 2'd1, "buffer count did not grow on push")

endmodule
